>>> rtl/ring_sample_corner_test_assert.svh
// Assertion macros for the ring sample corner test block.
// Expects clk and arst_n in the scope of each use.
`ifndef RING_SAMPLE_CORNER_TEST_ASSERT_SVH
`define RING_SAMPLE_CORNER_TEST_ASSERT_SVH

// same-cycle implication
`define RSCT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ring corner check failed");

// next-cycle implication
`define RSCT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ring corner check failed");

`endif

>>> rtl/rsct_pkg.sv
// Shared types and constants of the ring sample corner test block.
// No dependencies.
package rsct_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CONTRAST_W = 8;
	localparam int SPREAD_W   = 7;
	localparam int RUN_W      = 7;
	localparam int SUM_W      = 14;

	localparam logic [CONTRAST_W-1:0] CONTRAST_RST = 8'd100;
	localparam logic [SPREAD_W-1:0]   SPREAD_RST   = 7'd6;

	localparam logic [CFG_IDX_W-1:0] REG_CONTRAST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPREAD   = 2'd1;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             bank;
		logic             low_contrast;
	} job_t;

endpackage

>>> rtl/rsct_ifs.sv
// Handshake channels of the ring sample corner test block: samples, verdicts, register writes.
// Depends on rsct_pkg.
interface rsct_sample_if;
	logic                          valid;
	logic                          ready;
	logic [rsct_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface rsct_result_if;
	logic                       valid;
	logic                       ready;
	logic                       is_corner;
	logic                       low_contrast;
	logic [rsct_pkg::RUN_W-1:0] run_count;
	logic [rsct_pkg::RUN_W-1:0] run_spread;

	modport source (output valid, output is_corner, output low_contrast, output run_count,
		output run_spread, input ready);
	modport sink (input valid, input is_corner, input low_contrast, input run_count,
		input run_spread, output ready);
endinterface

interface rsct_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rsct_pkg::CFG_IDX_W-1:0]  index;
	logic [rsct_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/rsct_front.sv
// Front end: accepts ring samples, writes them to the ring store, keeps sum, min and max.
// Issues one job per completed ring. Depends on rsct_pkg and rsct_ifs.
module rsct_front #(
	parameter int RING_POINTS = 32,
	localparam int IDX_W = $clog2(RING_POINTS),
	localparam int ADDR_W = IDX_W + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rsct_sample_if.sink                   samples,
	input  logic [rsct_pkg::CONTRAST_W-1:0] contrast_min,
	input  logic                          bank_free,
	output logic                          wr_en,
	output logic [ADDR_W-1:0]             wr_addr,
	output logic [rsct_pkg::SAMPLE_W-1:0] wr_data,
	output logic                          job_push,
	output rsct_pkg::job_t                job
);

	localparam logic [IDX_W-1:0] LAST  = IDX_W'(RING_POINTS - 1);
	localparam logic [1:0]       BANKS = 2'd2;

	logic [IDX_W-1:0]                fill_q;
	logic                            bank_q;
	logic [1:0]                      busy_q;
	logic [rsct_pkg::SUM_W-1:0]      sum_q;
	logic [rsct_pkg::SAMPLE_W-1:0]   low_q;
	logic [rsct_pkg::SAMPLE_W-1:0]   high_q;

	logic                            accept;
	logic                            last;
	logic [rsct_pkg::SUM_W-1:0]      nxt_sum;
	logic [rsct_pkg::SAMPLE_W-1:0]   nxt_low;
	logic [rsct_pkg::SAMPLE_W-1:0]   nxt_high;

	assign samples.ready = !((fill_q == '0) && (busy_q == BANKS));
	assign accept        = samples.valid && samples.ready;
	assign last          = (fill_q == LAST);

	assign nxt_sum  = sum_q + rsct_pkg::SUM_W'(samples.sample);
	assign nxt_low  = (samples.sample < low_q) ? samples.sample : low_q;
	assign nxt_high = (samples.sample > high_q) ? samples.sample : high_q;

	assign wr_en   = accept;
	assign wr_addr = {bank_q, fill_q};
	assign wr_data = samples.sample;

	assign job_push         = accept && last;
	assign job.sum          = nxt_sum;
	assign job.bank         = bank_q;
	assign job.low_contrast = ((nxt_high - nxt_low) < contrast_min);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			bank_q <= 1'b0;
			sum_q  <= '0;
			low_q  <= '1;
			high_q <= '0;
		end else if (accept) begin
			if (last) begin
				fill_q <= '0;
				bank_q <= ~bank_q;
				sum_q  <= '0;
				low_q  <= '1;
				high_q <= '0;
			end else begin
				fill_q <= fill_q + IDX_W'(1);
				sum_q  <= nxt_sum;
				low_q  <= nxt_low;
				high_q <= nxt_high;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			case ({job_push, bank_free})
				2'b10:   busy_q <= busy_q + 2'd1;
				2'b01:   busy_q <= busy_q - 2'd1;
				default: busy_q <= busy_q;
			endcase
		end
	end

endmodule

>>> rtl/rsct_queue.sv
// Two-entry job queue between the front end and the ring walker.
// Depends on rsct_pkg.
module rsct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsct_pkg::job_t din,
	input  logic           pop,
	output logic           valid,
	output rsct_pkg::job_t dout
);

	rsct_pkg::job_t entries_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign valid = (count_q != 2'd0);
	assign dout  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/rsct_back.sv
// Back end: holds the two-bank ring store, walks a stored ring, counts runs and forms the verdict.
// Depends on rsct_pkg and rsct_ifs.
module rsct_back #(
	parameter int RING_POINTS = 32,
	localparam int IDX_W = $clog2(RING_POINTS),
	localparam int ADDR_W = IDX_W + 1,
	localparam int CNT_W = $clog2(RING_POINTS + 2)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  rsct_pkg::job_t                job,
	output logic                          job_pop,
	input  logic                          wr_en,
	input  logic [ADDR_W-1:0]             wr_addr,
	input  logic [rsct_pkg::SAMPLE_W-1:0] wr_data,
	output logic                          bank_free,
	input  logic [rsct_pkg::SPREAD_W-1:0] spread_max,
	rsct_result_if.source                 verdicts
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_WALK = 2'd1;
	localparam logic [1:0] B_LEN  = 2'd2;
	localparam logic [1:0] B_DONE = 2'd3;

	localparam logic [IDX_W-1:0] LAST   = IDX_W'(RING_POINTS - 1);
	localparam logic [CNT_W-1:0] RP_C   = CNT_W'(RING_POINTS);
	localparam logic [CNT_W-1:0] FOUR   = CNT_W'(4);

	logic [rsct_pkg::SAMPLE_W-1:0] mem_q [0:(1 << ADDR_W) - 1];

	logic [1:0]                    state_q;
	logic [rsct_pkg::SUM_W-1:0]    job_sum_q;
	logic                          job_bank_q;
	logic                          lowc_q;
	logic [CNT_W-1:0]              step_q;
	logic                          rvalid_s1;
	logic [CNT_W-1:0]              rstep_s1;
	logic [rsct_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic                          prev_bit_q;
	logic [CNT_W-1:0]              trans_q;
	logic [IDX_W-1:0]              pos_q [4];
	logic [CNT_W-1:0]              len_q [4];

	logic                          out_valid_q;
	logic                          out_corner_q;
	logic                          out_lowc_q;
	logic [rsct_pkg::RUN_W-1:0]    out_runs_q;
	logic [rsct_pkg::RUN_W-1:0]    out_spread_q;

	logic                          issue;
	logic [IDX_W-1:0]              rd_idx;
	logic [ADDR_W-1:0]             rd_addr;
	logic [rsct_pkg::SUM_W-1:0]    prod;
	logic                          bit_now;
	logic                          walk_end;
	logic                          four_runs;
	logic [CNT_W-1:0]              mn01, mn23, mx01, mx23, len_min, len_max;
	logic [rsct_pkg::RUN_W-1:0]    spread;
	logic [rsct_pkg::RUN_W-1:0]    runs;
	logic                          out_load;

	assign job_pop  = (state_q == B_IDLE) && job_valid;
	assign issue    = (state_q == B_WALK) && (step_q <= RP_C);
	assign rd_idx   = (step_q == '0) ? LAST : IDX_W'(step_q - CNT_W'(1));
	assign rd_addr  = {job_bank_q, rd_idx};
	assign prod     = rsct_pkg::SUM_W'(rd_data_s1) * rsct_pkg::SUM_W'(RING_POINTS);
	assign bit_now  = (prod > job_sum_q);
	assign walk_end = (state_q == B_WALK) && rvalid_s1 && (rstep_s1 == RP_C);

	assign bank_free = (job_pop && job.low_contrast) || walk_end;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	assign four_runs = !lowc_q && (trans_q == FOUR);
	assign mn01      = (len_q[0] < len_q[1]) ? len_q[0] : len_q[1];
	assign mn23      = (len_q[2] < len_q[3]) ? len_q[2] : len_q[3];
	assign mx01      = (len_q[0] > len_q[1]) ? len_q[0] : len_q[1];
	assign mx23      = (len_q[2] > len_q[3]) ? len_q[2] : len_q[3];
	assign len_min   = (mn01 < mn23) ? mn01 : mn23;
	assign len_max   = (mx01 > mx23) ? mx01 : mx23;
	assign spread    = four_runs ? rsct_pkg::RUN_W'(len_max - len_min) : '0;
	assign runs      = lowc_q ? '0 :
		((trans_q == '0) ? rsct_pkg::RUN_W'(1) : rsct_pkg::RUN_W'(trans_q));
	assign out_load  = (state_q == B_DONE) && (!out_valid_q || verdicts.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			step_q     <= '0;
			rvalid_s1  <= 1'b0;
			rstep_s1   <= '0;
			trans_q    <= '0;
			prev_bit_q <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			rstep_s1  <= step_q;
			if (issue) begin
				step_q <= step_q + CNT_W'(1);
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						step_q  <= '0;
						trans_q <= '0;
						state_q <= job.low_contrast ? B_DONE : B_WALK;
					end
				end
				B_WALK: begin
					if (rvalid_s1) begin
						prev_bit_q <= bit_now;
						if ((rstep_s1 != '0) && (bit_now != prev_bit_q)) begin
							trans_q <= trans_q + CNT_W'(1);
						end
						if (walk_end) begin
							state_q <= B_LEN;
						end
					end
				end
				B_LEN: begin
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_sum_q  <= job.sum;
			job_bank_q <= job.bank;
			lowc_q     <= job.low_contrast;
		end
		if ((state_q == B_WALK) && rvalid_s1 && (rstep_s1 != '0) && (bit_now != prev_bit_q)
			&& (trans_q < FOUR)) begin
			pos_q[trans_q[1:0]] <= IDX_W'(rstep_s1 - CNT_W'(1));
		end
		if (state_q == B_LEN) begin
			len_q[0] <= CNT_W'(pos_q[1]) - CNT_W'(pos_q[0]);
			len_q[1] <= CNT_W'(pos_q[2]) - CNT_W'(pos_q[1]);
			len_q[2] <= CNT_W'(pos_q[3]) - CNT_W'(pos_q[2]);
			len_q[3] <= CNT_W'(pos_q[0]) + RP_C - CNT_W'(pos_q[3]);
		end
		if (out_load) begin
			out_corner_q <= four_runs && (spread <= rsct_pkg::RUN_W'(spread_max));
			out_lowc_q   <= lowc_q;
			out_runs_q   <= runs;
			out_spread_q <= spread;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign verdicts.valid        = out_valid_q;
	assign verdicts.is_corner    = out_corner_q;
	assign verdicts.low_contrast = out_lowc_q;
	assign verdicts.run_count    = out_runs_q;
	assign verdicts.run_spread   = out_spread_q;

endmodule

>>> rtl/ring_sample_corner_test.sv
// Ring sample corner test: one sample per cycle in while a bank of the ring store is free,
// one verdict per ring of RING_POINTS out. Each completed ring goes as a job through the
// queue to the back end, which walks the stored ring (one store read per cycle) unless
// the ring has low contrast; the front end fills the other bank meanwhile.
// Reset: asynchronous, active low; registers return to contrast 100 and spread 6.
module ring_sample_corner_test #(
	parameter int RING_POINTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	rsct_sample_if.sink   samples,
	rsct_result_if.source verdicts,
	rsct_cfg_if.sink      cfg
);

	localparam int IDX_W  = $clog2(RING_POINTS);
	localparam int ADDR_W = IDX_W + 1;

	logic [rsct_pkg::CONTRAST_W-1:0] contrast_q;
	logic [rsct_pkg::SPREAD_W-1:0]   spread_q;

	logic                            wr_en;
	logic [ADDR_W-1:0]               wr_addr;
	logic [rsct_pkg::SAMPLE_W-1:0]   wr_data;
	logic                            job_push;
	rsct_pkg::job_t                  job_in;
	logic                            job_pop;
	logic                            job_valid;
	rsct_pkg::job_t                  job_out;
	logic                            bank_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q <= rsct_pkg::CONTRAST_RST;
			spread_q   <= rsct_pkg::SPREAD_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				rsct_pkg::REG_CONTRAST: contrast_q <= cfg.data;
				rsct_pkg::REG_SPREAD:   spread_q   <= cfg.data[rsct_pkg::SPREAD_W-1:0];
				default: ;
			endcase
		end
	end

	rsct_front #(.RING_POINTS(RING_POINTS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples),
		.contrast_min (contrast_q),
		.bank_free    (bank_free),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.job_push     (job_push),
		.job          (job_in)
	);

	rsct_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.valid  (job_valid),
		.dout   (job_out)
	);

	rsct_back #(.RING_POINTS(RING_POINTS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_valid),
		.job        (job_out),
		.job_pop    (job_pop),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.bank_free  (bank_free),
		.spread_max (spread_q),
		.verdicts   (verdicts)
	);

endmodule

>>> rtl/rsct_checker.sv
// Port-level checks of the ring sample corner test block, bound to its top level.
// Depends on rsct_pkg and ring_sample_corner_test_assert.svh.
`include "ring_sample_corner_test_assert.svh"

module rsct_checker #(
	parameter int RING_POINTS = 32
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       is_corner,
	input logic                       low_contrast,
	input logic [rsct_pkg::RUN_W-1:0] run_count,
	input logic [rsct_pkg::RUN_W-1:0] run_spread
);

	localparam int IDX_W = $clog2(RING_POINTS);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_POINTS - 1);
	localparam logic [rsct_pkg::RUN_W-1:0] FOUR = rsct_pkg::RUN_W'(4);

	logic [IDX_W-1:0]                 cnt_q;
	logic [2:0]                       pending_q;
	logic                             ring_done;
	logic                             out_xfer;
	logic [2*rsct_pkg::RUN_W+1:0]     out_fields;

	assign ring_done  = in_valid && in_ready && (cnt_q == LAST);
	assign out_xfer   = out_valid && out_ready;
	assign out_fields = {is_corner, low_contrast, run_count, run_spread};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pending_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				cnt_q <= (cnt_q == LAST) ? '0 : cnt_q + IDX_W'(1);
			end
			case ({ring_done, out_xfer})
				2'b10:   pending_q <= pending_q + 3'd1;
				2'b01:   pending_q <= pending_q - 3'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	`RSCT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))
	`RSCT_ASSERT_IMP(a_no_orphan, out_valid, pending_q != 3'd0)
	`RSCT_ASSERT_IMP(a_corner_runs, out_valid && is_corner, !low_contrast && (run_count == FOUR))
	`RSCT_ASSERT_IMP(a_lowc_empty, out_valid && low_contrast, (run_count == '0) && (run_spread == '0))
	`RSCT_ASSERT_IMP(a_spread_four, out_valid && (run_spread != '0), run_count == FOUR)

endmodule

bind ring_sample_corner_test rsct_checker #(.RING_POINTS(RING_POINTS)) u_rsct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.out_valid    (verdicts.valid),
	.out_ready    (verdicts.ready),
	.is_corner    (verdicts.is_corner),
	.low_contrast (verdicts.low_contrast),
	.run_count    (verdicts.run_count),
	.run_spread   (verdicts.run_spread)
);

>>> tb/tb.sv
// Self-checking bench for the ring sample corner test block: whole rings of gray samples,
// verdicts predicted per ring and compared field by field, random stalls on both channels.
// Depends on rsct_pkg, the rsct_*_if channel interfaces and ring_sample_corner_test.
module tb;

	localparam int RING_N = 32;
	localparam int LIMIT_CYCLES = 300000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		bit                       is_corner;
		bit                       low_contrast;
		bit [rsct_pkg::RUN_W-1:0] run_count;
		bit [rsct_pkg::RUN_W-1:0] run_spread;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsct_sample_if samples();
	rsct_result_if verdicts();
	rsct_cfg_if    cfg();

	ring_sample_corner_test #(.RING_POINTS(RING_N)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.verdicts (verdicts),
		.cfg      (cfg)
	);

	always #1 clk = ~clk;

	logic [rsct_pkg::SAMPLE_W-1:0] pending_samples[$];
	verdict_t                      ring_verdicts[$];
	int                            sent_total = 0;
	int                            taken_total = 0;
	int                            failures = 0;
	int                            cycle_count = 0;
	bit                            sample_taken = 0;
	bit                            calm = 0;
	bit                            hold_wanted = 0;

	// shadow of the block
	bit [rsct_pkg::CONTRAST_W-1:0] contrast_reg = rsct_pkg::CONTRAST_RST;
	bit [rsct_pkg::SPREAD_W-1:0]   spread_reg = rsct_pkg::SPREAD_RST;
	bit [rsct_pkg::SAMPLE_W-1:0]   ring_vals[RING_N];
	bit [rsct_pkg::SUM_W-1:0]      ring_sum = '0;
	bit [rsct_pkg::SAMPLE_W-1:0]   ring_lo = 8'd255;
	bit [rsct_pkg::SAMPLE_W-1:0]   ring_hi = 8'd0;
	int                            ring_fill = 0;

	function automatic verdict_t grade_ring();
		verdict_t v;
		int flips;
		int prev;
		bit cur_bit;
		bit prev_bit;
		int edges[4];
		int lens[4];
		int shortest;
		int longest;
		v = '{default: 0};
		flips = 0;
		if (int'(ring_hi) - int'(ring_lo) < int'(contrast_reg)) begin
			v.low_contrast = 1'b1;
		end else begin
			for (int k = 0; k < RING_N; k++) begin
				prev = (k == 0) ? RING_N - 1 : k - 1;
				cur_bit = int'(ring_vals[k]) * RING_N > int'(ring_sum);
				prev_bit = int'(ring_vals[prev]) * RING_N > int'(ring_sum);
				if (cur_bit != prev_bit) begin
					if (flips < 4)
						edges[flips] = k;
					flips++;
				end
			end
			v.run_count = rsct_pkg::RUN_W'((flips == 0) ? 1 : flips);
			if (flips == 4) begin
				lens[0] = edges[1] - edges[0];
				lens[1] = edges[2] - edges[1];
				lens[2] = edges[3] - edges[2];
				lens[3] = edges[0] + RING_N - edges[3];
				shortest = lens[0];
				longest = lens[0];
				for (int k = 1; k < 4; k++) begin
					if (lens[k] < shortest) shortest = lens[k];
					if (lens[k] > longest) longest = lens[k];
				end
				v.run_spread = rsct_pkg::RUN_W'(longest - shortest);
				v.is_corner = (longest - shortest) <= int'(spread_reg);
			end
		end
		return v;
	endfunction

	// input side: register writes and sample transfers feed the shadow
	always @(posedge clk) begin
		sample_taken = samples.valid && samples.ready;
		if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rsct_pkg::REG_CONTRAST: contrast_reg = cfg.data;
				rsct_pkg::REG_SPREAD: spread_reg = cfg.data[rsct_pkg::SPREAD_W-1:0];
				default: ;
			endcase
		end
		if (sample_taken) begin
			taken_total++;
			ring_vals[ring_fill] = samples.sample;
			ring_sum = ring_sum + samples.sample;
			if (samples.sample < ring_lo) ring_lo = samples.sample;
			if (samples.sample > ring_hi) ring_hi = samples.sample;
			ring_fill++;
			if (ring_fill == RING_N) begin
				ring_verdicts.insert(ring_verdicts.size(), grade_ring());
				ring_fill = 0;
				ring_sum = '0;
				ring_lo = 8'd255;
				ring_hi = 8'd0;
			end
		end
	end

	// output side
	always @(posedge clk) begin
		verdict_t want;
		if (verdicts.valid && verdicts.ready) begin
			if (ring_verdicts.size() == 0) begin
				$error("verdict transfer with no ring pending");
				failures++;
			end else begin
				want = ring_verdicts.pop_front();
				if (verdicts.is_corner !== want.is_corner) begin
					$error("is_corner: expected %0d, got %0d", want.is_corner, verdicts.is_corner);
					failures++;
				end
				if (verdicts.low_contrast !== want.low_contrast) begin
					$error("low_contrast: expected %0d, got %0d", want.low_contrast,
						verdicts.low_contrast);
					failures++;
				end
				if (verdicts.run_count !== want.run_count) begin
					$error("run_count: expected %0d, got %0d", want.run_count, verdicts.run_count);
					failures++;
				end
				if (verdicts.run_spread !== want.run_spread) begin
					$error("run_spread: expected %0d, got %0d", want.run_spread,
						verdicts.run_spread);
					failures++;
				end
			end
		end
	end

	// sample driver
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!samples.valid || sample_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				samples.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				gap_left = $urandom_range(1, 18) - 1;
				samples.valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				samples.valid <= 1'b1;
				samples.sample <= pending_samples.pop_front();
			end else begin
				samples.valid <= 1'b0;
			end
		end
	end

	// verdict receiver
	int stall_left = 0;
	int hold_left = 0;
	bit hold_spent = 0;
	always @(negedge clk) begin
		if (hold_wanted && !hold_spent) begin
			hold_spent = 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			verdicts.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			verdicts.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			verdicts.ready <= 1'b0;
		end else begin
			verdicts.ready <= 1'b1;
		end
	end

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	task automatic add_sample(input int v);
		pending_samples.insert(pending_samples.size(), v[rsct_pkg::SAMPLE_W-1:0]);
		sent_total++;
	endtask

	// four runs alternating hi and lo, rotated round the ring, with optional jitter
	task automatic queue_corner(input int lo, input int hi, input int l0, input int l1,
		input int l2, input int l3, input int rot, input int jitter);
		int ring[RING_N];
		int lens[4];
		int pos;
		int v;
		lens = '{l0, l1, l2, l3};
		pos = 0;
		for (int r = 0; r < 4; r++) begin
			for (int k = 0; k < lens[r]; k++) begin
				v = ((r % 2) ? lo : hi) - jitter + int'($urandom_range(0, 2 * jitter));
				if (v < 0) v = 0;
				if (v > 255) v = 255;
				ring[(pos + rot) % RING_N] = v;
				pos++;
			end
		end
		for (int k = 0; k < RING_N; k++)
			add_sample(ring[k]);
	endtask

	task automatic write_reg(input logic [rsct_pkg::CFG_IDX_W-1:0] idx,
		input logic [rsct_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		while (taken_total != sent_total || ring_verdicts.size() != 0)
			@(negedge clk);
		repeat (RING_N + 8) @(negedge clk);
	endtask

	initial begin
		int lens[4];
		int a;
		int b;
		int lo;
		int hi;
		int kind;
		samples.valid = 1'b0;
		samples.sample = '0;
		verdicts.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = rsct_pkg::REG_CONTRAST;
		cfg.data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset settings
		queue_corner(0, 0, 8, 8, 8, 8, 0, 0);
		queue_corner(0, 255, 8, 8, 8, 8, 0, 0);
		queue_corner(0, 255, 8, 8, 8, 8, 5, 0);
		queue_corner(0, 99, 8, 8, 8, 8, 0, 0);
		queue_corner(0, 100, 8, 8, 8, 8, 3, 0);
		queue_corner(0, 255, 11, 4, 9, 8, 0, 0);
		queue_corner(10, 200, 11, 5, 8, 8, 2, 0);
		queue_corner(0, 255, 16, 16, 0, 0, 7, 0);
		for (int k = 0; k < RING_N; k++)
			add_sample(k < 8 ? 0 : (k < 16 ? 100 : 50));
		for (int k = 0; k < RING_N; k++)
			add_sample((k % 2) ? 255 : 0);
		drain();

		write_reg(rsct_pkg::REG_CONTRAST, 8'd0);
		write_reg(rsct_pkg::REG_SPREAD, 8'd0);
		write_reg(2'd2, 8'($urandom_range(0, 255)));
		write_reg(2'd3, 8'($urandom_range(0, 255)));
		queue_corner(128, 128, 8, 8, 8, 8, 0, 0);
		queue_corner(255, 255, 8, 8, 8, 8, 0, 0);
		queue_corner(0, 1, 8, 8, 8, 8, 9, 0);
		queue_corner(0, 1, 9, 7, 8, 8, 0, 0);
		drain();

		write_reg(rsct_pkg::REG_CONTRAST, 8'd255);
		write_reg(rsct_pkg::REG_SPREAD, 8'hFF);
		queue_corner(0, 255, 1, 1, 1, 29, 0, 0);
		queue_corner(1, 255, 8, 8, 8, 8, 0, 0);
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(rsct_pkg::REG_CONTRAST, 8'($urandom_range(0, 150)));
			write_reg(rsct_pkg::REG_SPREAD, {1'($urandom_range(0, 1)), 7'($urandom_range(0, 12))});
			if (p == 1) hold_wanted = 1;
			if (p == 4) calm = 1;
			for (int r = 0; r < ((p == 1) ? 6 : 4); r++) begin
				kind = $urandom_range(0, 9);
				if (kind < 6) begin
					lens = '{8, 8, 8, 8};
					repeat ($urandom_range(0, 6)) begin
						a = $urandom_range(0, 3);
						b = $urandom_range(0, 3);
						if (lens[a] > 1) begin
							lens[a]--;
							lens[b]++;
						end
					end
					lo = $urandom_range(0, 127);
					hi = $urandom_range(lo, 255);
					queue_corner(lo, hi, lens[0], lens[1], lens[2], lens[3],
						$urandom_range(0, RING_N - 1),
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : 0);
				end else if (kind < 8) begin
					for (int k = 0; k < RING_N; k++)
						add_sample($urandom_range(0, 255));
				end else begin
					lo = $urandom_range(0, 255);
					queue_corner(lo, lo, 8, 8, 8, 8, 0, $urandom_range(0, 20));
				end
			end
			drain();
		end

		if (failures == 0 && ring_verdicts.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end
endmodule
